[rtl/sfq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_pkg: shared types and codes of the searchable FIFO queue
// Field widths, request and result codes, and the command word that travels
// from the front end to the execution back end.
// ----------------------------------------------------------------------------
package sfq_pkg;

	localparam int ACT_W       = 2;
	localparam int VAL_W       = 32;
	localparam int ST_W        = 3;
	localparam int POS_W       = 4;
	localparam int CNT_W       = 5;
	localparam int MAX_RESULTS = 16;
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

	// Request actions.
	localparam logic [ACT_W-1:0] ACT_ENQ  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DEQ  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SRCH = 2'd2;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_MATCH    = 3'd4;

	typedef struct packed {
		logic [ACT_W-1:0]        op;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

endpackage

[rtl/sfq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_if: request and result channels of the searchable FIFO queue
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface sfq_in_if;
	logic                                valid;
	logic                                ready;
	logic [sfq_pkg::ACT_W-1:0]           action;
	logic signed [sfq_pkg::VAL_W-1:0]    value;

	modport source (output valid, action, value, input ready);
	modport sink (input valid, action, value, output ready);
endinterface

interface sfq_out_if;
	logic                                valid;
	logic                                ready;
	logic [sfq_pkg::ST_W-1:0]            status;
	logic signed [sfq_pkg::VAL_W-1:0]    data;
	logic [sfq_pkg::POS_W-1:0]           position;
	logic                                last;
	logic [sfq_pkg::CNT_W-1:0]           count;
	logic signed [sfq_pkg::VAL_W-1:0]    front_value;
	logic signed [sfq_pkg::VAL_W-1:0]    back_value;

	modport source (output valid, status, data, position, last, count, front_value,
		back_value, input ready);
	modport sink (input valid, status, data, position, last, count, front_value,
		back_value, output ready);
endinterface

[rtl/sfq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module sfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/sfq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_front: request intake and command queue
// Classifies each request, drops undefined actions, and buffers commands in
// a two-entry queue so intake and execution stall independently.
// ----------------------------------------------------------------------------
module sfq_front (
	input  logic           clk,
	input  logic           arst_n,
	sfq_in_if.sink         cmd,
	output logic           q_valid,
	output sfq_pkg::cmd_t  q_data,
	input  logic           q_pop
);

	localparam int QDEPTH = 2;
	localparam int QCW    = $clog2(QDEPTH + 1);

	sfq_pkg::cmd_t    slot_q [QDEPTH];
	logic             wr_q;
	logic             rd_q;
	logic [QCW-1:0]   cnt_q;
	logic             is_op;
	logic             push;

	always_comb begin
		case (cmd.action)
			sfq_pkg::ACT_ENQ,
			sfq_pkg::ACT_DEQ,
			sfq_pkg::ACT_SRCH: is_op = 1'b1;
			default:           is_op = 1'b0;
		endcase
	end

	assign cmd.ready = (cnt_q != QCW'(QDEPTH));
	assign push      = cmd.valid && cmd.ready && is_op;
	assign q_valid   = (cnt_q != '0);
	assign q_data    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{op: cmd.action, value: cmd.value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/sfq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_back: command execution and result register
// Keeps the ring buffer, its head, tail and fill count, and walks the held
// entries one per cycle for a search unless a match meets a stalled result.
// ----------------------------------------------------------------------------
module sfq_back #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  sfq_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	sfq_out_if.source      rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [sfq_pkg::NRES_W-1:0] LAST_RES =
		sfq_pkg::NRES_W'(sfq_pkg::MAX_RESULTS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEQ  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		ring_next = (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	logic [1:0]                        state_q, state_d;
	logic [AW-1:0]                     head_q, head_d;
	logic [AW-1:0]                     tail_q, tail_d;
	logic [CW-1:0]                     fill_q, fill_d;
	logic signed [sfq_pkg::VAL_W-1:0]  front_q, front_d;
	logic signed [sfq_pkg::VAL_W-1:0]  back_q, back_d;
	logic signed [sfq_pkg::VAL_W-1:0]  key_q, key_d;
	logic [AW-1:0]                     scan_addr_q, scan_addr_d;
	logic [CW-1:0]                     iss_q, iss_d;
	logic                              cmp_v_s1, cmp_v_d;
	logic [AW-1:0]                     pos_s1, pos_d;
	logic                              pend_q, pend_d;
	logic [AW-1:0]                     pend_pos_q, pend_pos_d;
	logic [sfq_pkg::NRES_W-1:0]        nres_q, nres_d;

	logic                              we;
	logic [AW-1:0]                     waddr;
	logic [sfq_pkg::VAL_W-1:0]         wdata;
	logic                              re;
	logic [AW-1:0]                     raddr;
	logic [sfq_pkg::VAL_W-1:0]         rdata;

	logic                              out_free;
	logic                              issuing;
	logic                              hit;
	logic                              emit;
	logic [sfq_pkg::ST_W-1:0]          e_status;
	logic signed [sfq_pkg::VAL_W-1:0]  e_data;
	logic [sfq_pkg::POS_W-1:0]         e_pos;
	logic                              e_last;
	logic [CW-1:0]                     e_fill;
	logic signed [sfq_pkg::VAL_W-1:0]  e_front;
	logic signed [sfq_pkg::VAL_W-1:0]  e_back;

	logic                              out_valid_q;
	logic [sfq_pkg::ST_W-1:0]          out_status_q;
	logic signed [sfq_pkg::VAL_W-1:0]  out_data_q;
	logic [sfq_pkg::POS_W-1:0]         out_pos_q;
	logic                              out_last_q;
	logic [sfq_pkg::CNT_W-1:0]         out_count_q;
	logic signed [sfq_pkg::VAL_W-1:0]  out_front_q;
	logic signed [sfq_pkg::VAL_W-1:0]  out_back_q;

	sfq_ram #(
		.WIDTH (sfq_pkg::VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign out_free = !out_valid_q || rsp.ready;
	assign issuing  = (iss_q < fill_q);
	assign hit      = cmp_v_s1 && (rdata == key_q);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		fill_d      = fill_q;
		front_d     = front_q;
		back_d      = back_q;
		key_d       = key_q;
		scan_addr_d = scan_addr_q;
		iss_d       = iss_q;
		cmp_v_d     = cmp_v_s1;
		pos_d       = pos_s1;
		pend_d      = pend_q;
		pend_pos_d  = pend_pos_q;
		nres_d      = nres_q;
		cmd_pop     = 1'b0;
		we          = 1'b0;
		waddr       = tail_q;
		wdata       = cmd.value;
		re          = 1'b0;
		raddr       = scan_addr_q;
		emit        = 1'b0;
		e_status    = sfq_pkg::ST_OK;
		e_data      = '0;
		e_pos       = '0;
		e_last      = 1'b1;
		e_fill      = fill_q;
		e_front     = front_q;
		e_back      = back_q;

		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						sfq_pkg::ACT_ENQ: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								emit    = 1'b1;
								if (fill_q == FULL_CNT) begin
									e_status = sfq_pkg::ST_FULL;
								end else begin
									we     = 1'b1;
									tail_d = ring_next(tail_q);
									fill_d = fill_q + 1'b1;
									back_d = cmd.value;
									if (fill_q == '0) begin
										front_d = cmd.value;
									end
									e_fill  = fill_d;
									e_front = front_d;
									e_back  = back_d;
								end
							end
						end
						sfq_pkg::ACT_DEQ: begin
							if (fill_q == '0) begin
								if (out_free) begin
									cmd_pop  = 1'b1;
									emit     = 1'b1;
									e_status = sfq_pkg::ST_EMPTY;
								end
							end else begin
								// Fetch the entry that becomes the new front.
								cmd_pop = 1'b1;
								re      = 1'b1;
								raddr   = ring_next(head_q);
								state_d = S_DEQ;
							end
						end
						sfq_pkg::ACT_SRCH: begin
							if (fill_q == '0) begin
								if (out_free) begin
									cmd_pop  = 1'b1;
									emit     = 1'b1;
									e_status = sfq_pkg::ST_NOTFOUND;
								end
							end else begin
								cmd_pop     = 1'b1;
								key_d       = cmd.value;
								scan_addr_d = head_q;
								iss_d       = '0;
								cmp_v_d     = 1'b0;
								pend_d      = 1'b0;
								nres_d      = '0;
								state_d     = S_SCAN;
							end
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			S_DEQ: begin
				if (out_free) begin
					emit    = 1'b1;
					e_data  = front_q;
					head_d  = ring_next(head_q);
					fill_d  = fill_q - 1'b1;
					front_d = rdata;
					e_fill  = fill_d;
					e_front = rdata;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				// A match waits for the next or the end so the final one can carry last.
				if (!(hit && pend_q && !out_free)) begin
					re      = issuing;
					cmp_v_d = issuing;
					if (issuing) begin
						scan_addr_d = ring_next(scan_addr_q);
						iss_d       = iss_q + 1'b1;
						pos_d       = iss_q[AW-1:0];
					end
					if (hit) begin
						if (pend_q) begin
							emit     = 1'b1;
							e_status = sfq_pkg::ST_MATCH;
							e_data   = key_q;
							e_pos    = sfq_pkg::POS_W'(pend_pos_q);
							e_last   = 1'b0;
						end
						pend_d     = 1'b1;
						pend_pos_d = pos_s1;
						nres_d     = nres_q + 1'b1;
						if (nres_q == LAST_RES) begin
							cmp_v_d = 1'b0;
							state_d = S_FIN;
						end
					end else if (!issuing && !cmp_v_s1) begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (pend_q) begin
						e_status = sfq_pkg::ST_MATCH;
						e_data   = key_q;
						e_pos    = sfq_pkg::POS_W'(pend_pos_q);
					end else begin
						e_status = sfq_pkg::ST_NOTFOUND;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		front_q     <= front_d;
		back_q      <= back_d;
		key_q       <= key_d;
		scan_addr_q <= scan_addr_d;
		pos_s1      <= pos_d;
		pend_pos_q  <= pend_pos_d;
		if (emit) begin
			out_status_q <= e_status;
			out_data_q   <= e_data;
			out_pos_q    <= e_pos;
			out_last_q   <= e_last;
			out_count_q  <= sfq_pkg::CNT_W'(e_fill);
			out_front_q  <= (e_fill == '0) ? '0 : e_front;
			out_back_q   <= (e_fill == '0) ? '0 : e_back;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			iss_q       <= '0;
			cmp_v_s1    <= 1'b0;
			pend_q      <= 1'b0;
			nres_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			fill_q   <= fill_d;
			iss_q    <= iss_d;
			cmp_v_s1 <= cmp_v_d;
			pend_q   <= pend_d;
			nres_q   <= nres_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.data        = out_data_q;
	assign rsp.position    = out_pos_q;
	assign rsp.last        = out_last_q;
	assign rsp.count       = out_count_q;
	assign rsp.front_value = out_front_q;
	assign rsp.back_value  = out_back_q;

endmodule

[rtl/searchable_fifo_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// searchable_fifo_queue: bounded FIFO of signed values with key search
// Enqueue, dequeue and search requests; a search returns the matching
// positions from the head, at most sixteen, the last one flagged.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  cmd     | in  | valid/ready | action, value
//  rsp     | out | valid/ready | status, data, position, last, count,
//          |     |             | front_value, back_value
//
// Enqueue and refused requests finish in the execution unit's idle state; a
// dequeue first reads the RAM for the new front. A search ends early at the
// sixteenth match; the single RAM read port reads one held entry per cycle
// unless a stalled result holds a match.
// Reset clears pointers, fill count and both queues; stored values need no clear.
// A stalled result holds the execution unit; the two-entry command queue keeps
// taking requests until it fills.
module searchable_fifo_queue #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sfq_in_if.sink     cmd,
	sfq_out_if.source  rsp
);

	logic           q_valid;
	sfq_pkg::cmd_t  q_data;
	logic           q_pop;

	sfq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	sfq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_data),
		.cmd_pop   (q_pop),
		.rsp       (rsp)
	);

endmodule

[rtl/sfq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_checker: result channel checks for the searchable FIFO queue
// Watches the result port and checks each result's fields, also while stalled.
// ----------------------------------------------------------------------------
module sfq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [sfq_pkg::ST_W-1:0]         status,
	input logic signed [sfq_pkg::VAL_W-1:0] data,
	input logic [sfq_pkg::POS_W-1:0]        position,
	input logic                             last,
	input logic [sfq_pkg::CNT_W-1:0]        count,
	input logic signed [sfq_pkg::VAL_W-1:0] front_value,
	input logic signed [sfq_pkg::VAL_W-1:0] back_value
);

	// A stalled result must hold its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(data)
			&& $stable(position) && $stable(last) && $stable(count))
		else $error("result changed while stalled");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && count == '0 |-> front_value == '0 && back_value == '0)
		else $error("front or back value shown on an empty queue");

	// Only search matches can be followed by more results of the same request.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == sfq_pkg::ST_OK || status == sfq_pkg::ST_FULL
			|| status == sfq_pkg::ST_EMPTY || status == sfq_pkg::ST_NOTFOUND)
			|-> last && position == '0)
		else $error("non-match result without last or with a position");

	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == sfq_pkg::ST_FULL || status == sfq_pkg::ST_EMPTY
			|| status == sfq_pkg::ST_NOTFOUND) |-> data == '0)
		else $error("refused or missed request carries data");

endmodule

bind searchable_fifo_queue sfq_checker u_sfq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.data        (rsp.data),
	.position    (rsp.position),
	.last        (rsp.last),
	.count       (rsp.count),
	.front_value (rsp.front_value),
	.back_value  (rsp.back_value)
);
